// ----- hw/rtl/pdsf_pkg.sv -----
package pdsf_pkg;

   localparam int VALUE_WIDTH   = 32;
   localparam int SUM_WIDTH     = 48;
   localparam int VALUE_FIELD_W = 32;
   localparam int SUM_FIELD_W   = 48;
   localparam int DIVISOR_W     = 8;

   // magnitude of a non-negative value
   localparam int NUM_W  = VALUE_WIDTH - 1;
   // trial divisor never exceeds the square root plus one
   localparam int DIV_W  = VALUE_WIDTH / 2;
   localparam int DV_W   = (DIV_W > DIVISOR_W) ? DIV_W : DIVISOR_W;
   localparam int SQ_W   = VALUE_WIDTH;
   localparam int DSUM_W = 7;
   localparam int CNT_W  = $clog2(NUM_W + 1);

   localparam int DIGIT_BASE = 10;

   typedef struct packed {
      logic             start;
      logic [NUM_W-1:0] dividend;
      logic [DV_W-1:0]  divisor;
   } div_req_type;

   typedef struct packed {
      logic             busy;
      logic             done;
      logic [NUM_W-1:0] quotient;
      logic [DV_W-1:0]  remainder;
   } div_rsp_type;

endpackage

// ----- hw/rtl/pdsf_req_if.sv -----
interface pdsf_req_if import pdsf_pkg::*; ();

   logic                            valid;
   logic                            ready;
   logic signed [VALUE_FIELD_W-1:0] value;
   logic                            last;

   modport source (output valid, output value, output last, input ready);
   modport sink (input valid, input value, input last, output ready);

endinterface

// ----- hw/rtl/pdsf_rsp_if.sv -----
interface pdsf_rsp_if import pdsf_pkg::*; ();

   logic                   valid;
   logic                   ready;
   logic                   prime;
   logic                   accepted;
   logic [SUM_FIELD_W-1:0] running_sum;
   logic                   saturated;
   logic                   group_end;

   modport source (
      output valid, output prime, output accepted, output running_sum,
      output saturated, output group_end, input ready
   );
   modport sink (
      input valid, input prime, input accepted, input running_sum,
      input saturated, input group_end, output ready
   );

endinterface

// ----- hw/rtl/pdsf_serdiv.sv -----
module pdsf_serdiv import pdsf_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  div_req_type div_req,
   output div_rsp_type div_rsp
);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [NUM_W-1:0] num_ff, num_in;
   logic [DV_W-1:0]  rem_ff, rem_in;
   logic [DV_W-1:0]  div_ff, div_in;

   logic [DV_W:0] trial;
   logic [DV_W:0] diff;
   logic          fits;

   // restoring division, one quotient bit per cycle
   always_comb begin
      trial = {rem_ff, num_ff[NUM_W-1]};
      diff  = trial - {1'b0, div_ff};
      fits  = trial >= {1'b0, div_ff};

      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      num_in  = num_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;

      if (div_req.start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(NUM_W);
         num_in  = div_req.dividend;
         rem_in  = '0;
         div_in  = div_req.divisor;
      end else if (busy_ff) begin
         num_in = {num_ff[NUM_W-2:0], fits};
         rem_in = fits ? diff[DV_W-1:0] : trial[DV_W-1:0];
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      num_ff <= num_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
   end

   assign div_rsp.busy      = busy_ff;
   assign div_rsp.done      = done_ff;
   assign div_rsp.quotient  = num_ff;
   assign div_rsp.remainder = rem_ff;

endmodule

// ----- hw/rtl/prime_digit_sum_filter_accumulator.sv -----
// Prime digit-sum filter accumulator. One item in gives one item out, and the block works on
// one item at a time: req_if.ready is high only while it is idle, though a finished item may
// still wait in the output register. Everything runs through one bit-serial divider that
// produces one quotient bit per cycle. A value n of two or more is divided by each trial
// divisor from 2 up to its first factor or up to sqrt(n); a prime then takes one division per
// decimal digit and one more for the digit-sum check, unless the divisor register is zero.
// The divisor register is written through csr_write_enable and csr_write_data and resets
// to one.
module prime_digit_sum_filter_accumulator import pdsf_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   pdsf_req_if.sink             req_if,
   pdsf_rsp_if.source           rsp_if,
   input  logic                 csr_write_enable,
   input  logic [DIVISOR_W-1:0] csr_write_data
);

   localparam logic [2:0] ST_IDLE     = 3'd0;
   localparam logic [2:0] ST_TEST     = 3'd1;
   localparam logic [2:0] ST_TRIAL    = 3'd2;
   localparam logic [2:0] ST_DIGIT    = 3'd3;
   localparam logic [2:0] ST_DIG_WAIT = 3'd4;
   localparam logic [2:0] ST_MOD_WAIT = 3'd5;
   localparam logic [2:0] ST_FINISH   = 3'd6;

   logic [2:0]           state_ff, state_in;
   logic [DIVISOR_W-1:0] divisor_ff, divisor_in;
   logic [NUM_W-1:0]     n_ff, n_in;
   logic                 last_ff, last_in;
   logic                 prime_ff, prime_in;
   logic                 acc_ff, acc_in;
   logic [DIV_W-1:0]     d_ff, d_in;
   logic [SQ_W-1:0]      sq_ff, sq_in;
   logic [NUM_W-1:0]     work_ff, work_in;
   logic [DSUM_W-1:0]    dsum_ff, dsum_in;
   logic [SUM_WIDTH-1:0] sum_ff, sum_in;
   logic                 sat_ff, sat_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   rsp_prime_ff, rsp_prime_in;
   logic                   rsp_accepted_ff, rsp_accepted_in;
   logic [SUM_FIELD_W-1:0] rsp_sum_ff, rsp_sum_in;
   logic                   rsp_sat_ff, rsp_sat_in;
   logic                   rsp_end_ff, rsp_end_in;

   div_req_type div_req;
   div_rsp_type div_rsp;

   logic [VALUE_WIDTH-1:0]           raw;
   logic [SUM_WIDTH:0]               total;
   logic [SUM_WIDTH-1:0]             new_sum;
   logic                             new_sat;
   logic [SUM_WIDTH+SUM_FIELD_W-1:0] sum_wide;
   logic                             out_free;

   pdsf_serdiv u_serdiv (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   assign raw      = req_if.value[VALUE_WIDTH-1:0];
   assign out_free = !rsp_valid_ff || rsp_if.ready;

   // saturating group sum
   always_comb begin
      total   = {1'b0, sum_ff} + (SUM_WIDTH + 1)'(n_ff);
      new_sum = sum_ff;
      new_sat = sat_ff;
      if (acc_ff) begin
         new_sum = total[SUM_WIDTH] ? '1 : total[SUM_WIDTH-1:0];
         new_sat = sat_ff || total[SUM_WIDTH] || (new_sum == '1);
      end
      sum_wide = {{SUM_FIELD_W{1'b0}}, new_sum};
   end

   always_comb begin
      state_in   = state_ff;
      divisor_in = csr_write_enable ? csr_write_data : divisor_ff;
      n_in       = n_ff;
      last_in    = last_ff;
      prime_in   = prime_ff;
      acc_in     = acc_ff;
      d_in       = d_ff;
      sq_in      = sq_ff;
      work_in    = work_ff;
      dsum_in    = dsum_ff;
      sum_in     = sum_ff;
      sat_in     = sat_ff;

      rsp_valid_in    = rsp_valid_ff && !rsp_if.ready;
      rsp_prime_in    = rsp_prime_ff;
      rsp_accepted_in = rsp_accepted_ff;
      rsp_sum_in      = rsp_sum_ff;
      rsp_sat_in      = rsp_sat_ff;
      rsp_end_in      = rsp_end_ff;

      div_req.start    = 1'b0;
      div_req.dividend = n_ff;
      div_req.divisor  = DV_W'(d_ff);

      unique case (state_ff)
         ST_IDLE: begin
            if (req_if.valid) begin
               n_in     = raw[NUM_W-1:0];
               last_in  = req_if.last;
               prime_in = 1'b0;
               acc_in   = 1'b0;
               d_in     = DIV_W'(2);
               sq_in    = SQ_W'(4);
               // negatives, zero and one are never prime
               if (raw[VALUE_WIDTH-1] || raw[NUM_W-1:0] <= NUM_W'(1)) begin
                  state_in = ST_FINISH;
               end else begin
                  state_in = ST_TEST;
               end
            end
         end
         ST_TEST: begin
            if (sq_ff > {1'b0, n_ff}) begin
               prime_in = 1'b1;
               work_in  = n_ff;
               dsum_in  = '0;
               state_in = (divisor_ff == '0) ? ST_FINISH : ST_DIGIT;
            end else begin
               div_req.start = 1'b1;
               state_in      = ST_TRIAL;
            end
         end
         ST_TRIAL: begin
            if (div_rsp.done) begin
               if (div_rsp.remainder == '0) begin
                  state_in = ST_FINISH;
               end else begin
                  // (d + 1)^2 = d^2 + 2d + 1
                  sq_in    = sq_ff + SQ_W'({d_ff, 1'b1});
                  d_in     = d_ff + DIV_W'(1);
                  state_in = ST_TEST;
               end
            end
         end
         ST_DIGIT: begin
            div_req.start = 1'b1;
            if (work_ff == '0) begin
               div_req.dividend = NUM_W'(dsum_ff);
               div_req.divisor  = DV_W'(divisor_ff);
               state_in         = ST_MOD_WAIT;
            end else begin
               div_req.dividend = work_ff;
               div_req.divisor  = DV_W'(DIGIT_BASE);
               state_in         = ST_DIG_WAIT;
            end
         end
         ST_DIG_WAIT: begin
            if (div_rsp.done) begin
               dsum_in  = dsum_ff + DSUM_W'(div_rsp.remainder[3:0]);
               work_in  = div_rsp.quotient;
               state_in = ST_DIGIT;
            end
         end
         ST_MOD_WAIT: begin
            if (div_rsp.done) begin
               acc_in   = (div_rsp.remainder == '0);
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               rsp_valid_in    = 1'b1;
               rsp_prime_in    = prime_ff;
               rsp_accepted_in = acc_ff;
               rsp_sum_in      = sum_wide[SUM_FIELD_W-1:0];
               rsp_sat_in      = new_sat;
               rsp_end_in      = last_ff;
               sum_in          = last_ff ? '0 : new_sum;
               sat_in          = last_ff ? 1'b0 : new_sat;
               state_in        = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         divisor_ff   <= DIVISOR_W'(1);
         sum_ff       <= '0;
         sat_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         divisor_ff   <= divisor_in;
         sum_ff       <= sum_in;
         sat_ff       <= sat_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      n_ff            <= n_in;
      last_ff         <= last_in;
      prime_ff        <= prime_in;
      acc_ff          <= acc_in;
      d_ff            <= d_in;
      sq_ff           <= sq_in;
      work_ff         <= work_in;
      dsum_ff         <= dsum_in;
      rsp_prime_ff    <= rsp_prime_in;
      rsp_accepted_ff <= rsp_accepted_in;
      rsp_sum_ff      <= rsp_sum_in;
      rsp_sat_ff      <= rsp_sat_in;
      rsp_end_ff      <= rsp_end_in;
   end

   assign req_if.ready       = (state_ff == ST_IDLE);
   assign rsp_if.valid       = rsp_valid_ff;
   assign rsp_if.prime       = rsp_prime_ff;
   assign rsp_if.accepted    = rsp_accepted_ff;
   assign rsp_if.running_sum = rsp_sum_ff;
   assign rsp_if.saturated   = rsp_sat_ff;
   assign rsp_if.group_end   = rsp_end_ff;

   a_square_tracks: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_TEST |-> sq_ff == SQ_W'(SQ_W'(d_ff) * SQ_W'(d_ff)))
      else $error("trial square out of step with trial divisor");

   a_no_start_busy: assert property (@(posedge clock) disable iff (reset)
      div_req.start |-> !div_rsp.busy)
      else $error("divider started while busy");

   a_done_expected: assert property (@(posedge clock) disable iff (reset)
      div_rsp.done |->
         (state_ff == ST_TRIAL || state_ff == ST_DIG_WAIT || state_ff == ST_MOD_WAIT))
      else $error("divider result with no one waiting");

   a_accept_needs_prime: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_prime_ff || !rsp_accepted_ff))
      else $error("item accepted without being prime");

endmodule
